// ===== src/gdwm_pkg.sv =====
// shared types and constants for the grid dirty window marker
package gdwm_pkg;

    // field widths
    localparam int IDX_W    = 16;
    localparam int DIM_W    = 9;
    localparam int RAD_W    = 5;
    localparam int NEWLY_W  = 12;
    localparam int TOTAL_W  = 17;
    localparam int FUNC_W   = 2;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int OUT_DW   = 32;

    // map memory row organization
    localparam int ROW_BITS = 64;
    localparam int LANE_W   = 6;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS      = 2'd2;

    // register reset values
    localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 9'd256;
    localparam logic [RAD_W-1:0] RADIUS_RST      = 5'd4;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SETUP,
        ST_BACK,
        ST_SCAN,
        ST_DRAIN,
        ST_RDWAIT,
        ST_DONE
    } state_t;

endpackage

// ===== src/gdwm_map.sv =====
// dirty map storage: one write port, one registered read port
module gdwm_map #(
    parameter int ROWS = 1024,
    parameter int AW   = 10
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [gdwm_pkg::ROW_BITS-1:0]  wr_data,
    input  logic [AW-1:0]                  rd_addr,
    output logic [gdwm_pkg::ROW_BITS-1:0]  rd_data
);

    logic [gdwm_pkg::ROW_BITS-1:0] mem [ROWS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, returns contents before a same-edge write
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/grid_dirty_window_marker_unit.sv =====
// Grid dirty window marker: keeps one dirty bit per grid cell and marks square windows.
// A mark command runs a 16-step restoring divider that splits the index into row and
// column, steps back to the top row of the window, then reads, merges and writes back
// one map cell per cycle through the row-wide map write port. An undefined command, or
// a mark or read whose index lies outside the grid, goes straight to its result. A clear
// command, and the pass after reset, sweeps the map one 64-bit row per cycle, with no
// item accepted meanwhile; the user must write configuration only between commands,
// with none in work, and the block itself does not enforce it. One item is in work at
// once.
module grid_dirty_window_marker_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 31
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gdwm_pkg::IDX_W-1:0]      s_tdata,   // [15:0] cell_index
    input  logic [gdwm_pkg::FUNC_W-1:0]     s_tuser,   // [1:0] func
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gdwm_pkg::OUT_DW-1:0]     m_tdata,   // [11:0] newly_marked,
                                                       // [28:12] total_dirty,
                                                       // [29] dirty_bit,
                                                       // [30] index_error, [31] zero
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gdwm_pkg::APB_AW-1:0]     paddr,
    input  logic [gdwm_pkg::APB_DW-1:0]     pwdata,
    output logic [gdwm_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int MAP_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int K_W       = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
    localparam int MAP_ROWS  = (MAP_CELLS + gdwm_pkg::ROW_BITS - 1) / gdwm_pkg::ROW_BITS;
    localparam int ROW_AW    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(MAP_ROWS - 1);

    localparam int DW = gdwm_pkg::DIM_W;
    localparam int LW = gdwm_pkg::LANE_W;

    // configuration registers
    logic [DW-1:0]               grid_width_reg;
    logic [DW-1:0]               grid_height_reg;
    logic [gdwm_pkg::RAD_W-1:0]  radius_reg;

    // sequencer and datapath registers
    gdwm_pkg::state_t            state_reg, state_next;
    logic [gdwm_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [gdwm_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                        cmd_clear_reg, cmd_clear_next;
    logic [gdwm_pkg::NEWLY_W-1:0] newly_reg, newly_next;
    logic [gdwm_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                        bit_reg, bit_next;
    logic                        err_reg, err_next;
    logic [gdwm_pkg::IDX_W-1:0]  quo_reg, quo_next;
    logic [DW-1:0]               rem_reg, rem_next;
    logic [3:0]                  div_cnt_reg, div_cnt_next;
    logic [K_W-1:0]              rb_reg, rb_next;
    logic [gdwm_pkg::RAD_W-1:0]  dy_reg, dy_next;
    logic [DW-1:0]               x_reg, x_next;
    logic [DW-1:0]               x0_reg, x0_next;
    logic [DW-1:0]               x1_reg, x1_next;
    logic [DW-1:0]               y_reg, y_next;
    logic [DW-1:0]               y1_reg, y1_next;
    logic [ROW_AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic                        pb_valid_reg, pb_valid_next;
    logic [ROW_AW-1:0]           pb_row_reg, pb_row_next;
    logic [LW-1:0]               pb_lane_reg, pb_lane_next;
    logic                        fw_valid_reg;
    logic [ROW_AW-1:0]           fw_row_reg;
    logic [gdwm_pkg::ROW_BITS-1:0] fw_data_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [gdwm_pkg::OUT_DW-1:0] out_data_reg, out_data_next;

    // combinational helpers
    logic [DW-1:0]               w_sat, h_sat;
    logic [gdwm_pkg::RAD_W-1:0]  r_sat;
    logic [2*DW-1:0]             n_cells;
    logic [DW:0]                 trial;
    logic                        trial_ge;
    logic [DW-1:0]               cy, cx, y0;
    logic [DW:0]                 cy_hi, cx_hi;
    logic [K_W-1:0]              k_addr;
    logic [gdwm_pkg::ROW_BITS-1:0] base_row, new_row, rd_data;
    logic                        old_bit;
    logic                        mem_we;
    logic [ROW_AW-1:0]           mem_waddr, mem_raddr;
    logic [gdwm_pkg::ROW_BITS-1:0] mem_wdata;
    logic                        cfg_wr;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= gdwm_pkg::GRID_WIDTH_RST;
            grid_height_reg <= gdwm_pkg::GRID_HEIGHT_RST;
            radius_reg      <= gdwm_pkg::RADIUS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                gdwm_pkg::REG_GRID_WIDTH:  grid_width_reg  <= pwdata[DW-1:0];
                gdwm_pkg::REG_GRID_HEIGHT: grid_height_reg <= pwdata[DW-1:0];
                gdwm_pkg::REG_RADIUS:      radius_reg      <= pwdata[gdwm_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            gdwm_pkg::REG_GRID_WIDTH:  prdata = gdwm_pkg::APB_DW'(grid_width_reg);
            gdwm_pkg::REG_GRID_HEIGHT: prdata = gdwm_pkg::APB_DW'(grid_height_reg);
            gdwm_pkg::REG_RADIUS:      prdata = gdwm_pkg::APB_DW'(radius_reg);
            default:                   prdata = '0;
        endcase
    end

    // saturated geometry and grid size
    assign w_sat = (int'(grid_width_reg) > MAX_WIDTH) ? DW'(MAX_WIDTH) : grid_width_reg;
    assign h_sat = (int'(grid_height_reg) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : grid_height_reg;
    assign r_sat = (int'(radius_reg) > MAX_RADIUS) ? gdwm_pkg::RAD_W'(MAX_RADIUS) : radius_reg;
    assign n_cells = w_sat * h_sat;

    // restoring divider step: shift in next dividend bit, subtract width if it fits
    assign trial    = {rem_reg, quo_reg[gdwm_pkg::IDX_W-1]};
    assign trial_ge = trial >= {1'b0, w_sat};

    // window bounds from row and column
    assign cy    = quo_reg[DW-1:0];
    assign cx    = rem_reg;
    assign y0    = (cy > DW'(r_sat)) ? cy - DW'(r_sat) : '0;
    assign cy_hi = {1'b0, cy} + (DW + 1)'(r_sat);
    assign cx_hi = {1'b0, cx} + (DW + 1)'(r_sat);

    // cell address of the scan position
    assign k_addr = rb_reg + K_W'(x_reg);

    // merge stage: forward the row written in the previous cycle, set the cell bit
    always_comb
    begin
        if (fw_valid_reg && (fw_row_reg == pb_row_reg))
        begin
            base_row = fw_data_reg;
        end
        else
        begin
            base_row = rd_data;
        end
        old_bit = base_row[pb_lane_reg];
        new_row = base_row | (gdwm_pkg::ROW_BITS'(1) << pb_lane_reg);
    end

    // map port steering
    always_comb
    begin
        if (state_reg == gdwm_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = pb_valid_reg;
            mem_waddr = pb_row_reg;
            mem_wdata = new_row;
        end
        if (state_reg == gdwm_pkg::ST_CHECK)
        begin
            mem_raddr = ROW_AW'(K_W'(idx_reg) >> LW);
        end
        else
        begin
            mem_raddr = ROW_AW'(k_addr >> LW);
        end
    end

    gdwm_map #(
        .ROWS (MAP_ROWS),
        .AW   (ROW_AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (rd_data)
    );

    // sequencer next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        cmd_clear_next = cmd_clear_reg;
        newly_next     = newly_reg;
        total_next     = total_reg;
        bit_next       = bit_reg;
        err_next       = err_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        rb_next        = rb_reg;
        dy_next        = dy_reg;
        x_next         = x_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y_next         = y_reg;
        y1_next        = y1_reg;
        clr_cnt_next   = clr_cnt_reg;
        pb_valid_next  = 1'b0;
        pb_row_next    = pb_row_reg;
        pb_lane_next   = pb_lane_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        s_tready       = 1'b0;

        case (state_reg)
            gdwm_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ROW)
                begin
                    clr_cnt_next = '0;
                    state_next   = cmd_clear_reg ? gdwm_pkg::ST_DONE : gdwm_pkg::ST_IDLE;
                end
            end
            gdwm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    func_next  = s_tuser;
                    idx_next   = s_tdata;
                    state_next = gdwm_pkg::ST_CHECK;
                end
            end
            gdwm_pkg::ST_CHECK:
            begin
                newly_next     = '0;
                bit_next       = 1'b0;
                err_next       = 1'b0;
                cmd_clear_next = 1'b0;
                quo_next       = idx_reg;
                rem_next       = '0;
                div_cnt_next   = '0;
                case (func_reg)
                    gdwm_pkg::FUNC_CLEAR:
                    begin
                        total_next     = '0;
                        cmd_clear_next = 1'b1;
                        clr_cnt_next   = '0;
                        state_next     = gdwm_pkg::ST_CLEAR;
                    end
                    gdwm_pkg::FUNC_MARK:
                    begin
                        if ((2 * DW)'(idx_reg) >= n_cells)
                        begin
                            err_next   = 1'b1;
                            state_next = gdwm_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = gdwm_pkg::ST_DIV;
                        end
                    end
                    gdwm_pkg::FUNC_READ:
                    begin
                        if ((2 * DW)'(idx_reg) >= n_cells)
                        begin
                            err_next   = 1'b1;
                            state_next = gdwm_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = gdwm_pkg::ST_RDWAIT;
                        end
                    end
                    default:
                    begin
                        state_next = gdwm_pkg::ST_DONE;
                    end
                endcase
            end
            gdwm_pkg::ST_DIV:
            begin
                quo_next     = {quo_reg[gdwm_pkg::IDX_W-2:0], trial_ge};
                rem_next     = trial_ge ? DW'(trial - {1'b0, w_sat}) : trial[DW-1:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 4'(gdwm_pkg::IDX_W - 1))
                begin
                    state_next = gdwm_pkg::ST_SETUP;
                end
            end
            gdwm_pkg::ST_SETUP:
            begin
                y_next  = y0;
                y1_next = (cy_hi < (DW + 1)'(h_sat - 1'b1)) ? cy_hi[DW-1:0] : h_sat - 1'b1;
                x0_next = (cx > DW'(r_sat)) ? cx - DW'(r_sat) : '0;
                x_next  = (cx > DW'(r_sat)) ? cx - DW'(r_sat) : '0;
                x1_next = (cx_hi < (DW + 1)'(w_sat - 1'b1)) ? cx_hi[DW-1:0] : w_sat - 1'b1;
                dy_next = gdwm_pkg::RAD_W'(cy - y0);
                rb_next = K_W'(idx_reg) - K_W'(cx);
                if (cy == y0)
                begin
                    state_next = gdwm_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = gdwm_pkg::ST_BACK;
                end
            end
            gdwm_pkg::ST_BACK:
            begin
                rb_next = rb_reg - K_W'(w_sat);
                dy_next = dy_reg - 1'b1;
                if (dy_reg == gdwm_pkg::RAD_W'(1))
                begin
                    state_next = gdwm_pkg::ST_SCAN;
                end
            end
            gdwm_pkg::ST_SCAN:
            begin
                pb_valid_next = 1'b1;
                pb_row_next   = ROW_AW'(k_addr >> LW);
                pb_lane_next  = k_addr[LW-1:0];
                if (x_reg == x1_reg)
                begin
                    if (y_reg == y1_reg)
                    begin
                        state_next = gdwm_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        x_next  = x0_reg;
                        y_next  = y_reg + 1'b1;
                        rb_next = rb_reg + K_W'(w_sat);
                    end
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            gdwm_pkg::ST_DRAIN:
            begin
                state_next = gdwm_pkg::ST_DONE;
            end
            gdwm_pkg::ST_RDWAIT:
            begin
                bit_next   = rd_data[idx_reg[LW-1:0]];
                state_next = gdwm_pkg::ST_DONE;
            end
            gdwm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, err_reg, bit_reg, total_reg, newly_reg};
                    state_next     = gdwm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gdwm_pkg::ST_IDLE;
            end
        endcase

        // count cells that the merge stage sets for the first time
        if (pb_valid_reg && !old_bit)
        begin
            newly_next = newly_reg + 1'b1;
            total_next = total_reg + 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdwm_pkg::ST_CLEAR;
            cmd_clear_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            pb_valid_reg  <= 1'b0;
            fw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_clear_reg <= cmd_clear_next;
            clr_cnt_reg   <= clr_cnt_next;
            total_reg     <= total_next;
            pb_valid_reg  <= pb_valid_next;
            fw_valid_reg  <= pb_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        idx_reg      <= idx_next;
        newly_reg    <= newly_next;
        bit_reg      <= bit_next;
        err_reg      <= err_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        rb_reg       <= rb_next;
        dy_reg       <= dy_next;
        x_reg        <= x_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        y_reg        <= y_next;
        y1_reg       <= y1_next;
        pb_row_reg   <= pb_row_next;
        pb_lane_reg  <= pb_lane_next;
        fw_row_reg   <= pb_row_reg;
        fw_data_reg  <= new_row;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== verif/tb.sv =====
// testbench for the grid dirty window marker: directed and random command streams
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // function code with no defined action
    localparam logic [gdwm_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int MAP_CELLS    = 256 * 256;
    localparam int SIDE_MAX     = 256;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;

    // one result transaction as it sits in m_tdata
    typedef struct packed {
        logic        pad;
        logic        index_error;
        logic        dirty_bit;
        logic [16:0] total_dirty;
        logic [11:0] newly_marked;
    } marker_result_t;

    // predictor of the dirty map plus the store of results still owed
    class dirty_map_scoreboard;
        bit             dirty_cell [MAP_CELLS];
        logic [16:0]    marked_total;
        logic [8:0]     width_reg;
        logic [8:0]     height_reg;
        logic [4:0]     radius_reg;
        marker_result_t owed_results [$];
        int             mismatches;
        int             results_seen;

        function new();
            foreach (dirty_cell[i]) dirty_cell[i] = 1'b0;
            marked_total = '0;
            width_reg    = gdwm_pkg::GRID_WIDTH_RST;
            height_reg   = gdwm_pkg::GRID_HEIGHT_RST;
            radius_reg   = gdwm_pkg::RADIUS_RST;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        function void write_register(logic [1:0] index, logic [31:0] value);
            case (index)
                gdwm_pkg::REG_GRID_WIDTH:  width_reg  = value[8:0];
                gdwm_pkg::REG_GRID_HEIGHT: height_reg = value[8:0];
                gdwm_pkg::REG_RADIUS:      radius_reg = value[4:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(logic [1:0] index);
            case (index)
                gdwm_pkg::REG_GRID_WIDTH:  return {23'd0, width_reg};
                gdwm_pkg::REG_GRID_HEIGHT: return {23'd0, height_reg};
                gdwm_pkg::REG_RADIUS:      return {27'd0, radius_reg};
                default:                   return '0;
            endcase
        endfunction

        // sizes in use after saturation
        function int unsigned used_width();
            return (width_reg > SIDE_MAX) ? SIDE_MAX : width_reg;
        endfunction

        function int unsigned used_height();
            return (height_reg > SIDE_MAX) ? SIDE_MAX : height_reg;
        endfunction

        function int unsigned used_radius();
            return radius_reg;
        endfunction

        function int unsigned cells_in_use();
            return used_width() * used_height();
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // predict the result of one accepted command and update the map
        function void note_command(logic [1:0] func, logic [15:0] cell_index);
            int unsigned    w, h, r, n, row, col, y0, y1, x0, x1, k;
            int unsigned    newly;
            marker_result_t res;
            w = used_width();
            h = used_height();
            r = used_radius();
            n = w * h;
            newly = 0;
            res = '0;
            case (func)
                gdwm_pkg::FUNC_CLEAR:
                begin
                    foreach (dirty_cell[i]) dirty_cell[i] = 1'b0;
                    marked_total = '0;
                end
                gdwm_pkg::FUNC_MARK, gdwm_pkg::FUNC_READ:
                begin
                    if (cell_index >= n)
                        res.index_error = 1'b1;
                    else if (func == gdwm_pkg::FUNC_READ)
                        res.dirty_bit = dirty_cell[cell_index];
                    else
                    begin
                        // square window clipped to the grid
                        row = cell_index / w;
                        col = cell_index % w;
                        y0 = (row > r) ? row - r : 0;
                        y1 = (row + r < h - 1) ? row + r : h - 1;
                        x0 = (col > r) ? col - r : 0;
                        x1 = (col + r < w - 1) ? col + r : w - 1;
                        for (int unsigned y = y0; y <= y1; y++)
                        begin
                            for (int unsigned x = x0; x <= x1; x++)
                            begin
                                k = y * w + x;
                                if (!dirty_cell[k])
                                begin
                                    dirty_cell[k] = 1'b1;
                                    newly++;
                                end
                            end
                        end
                        marked_total = marked_total + newly[16:0];
                    end
                end
                default: ;
            endcase
            res.newly_marked = newly[11:0];
            res.total_dirty  = marked_total;
            owed_results.insert(owed_results.size(), res);
        endfunction

        // compare one result transaction with the oldest prediction
        task check_result(logic [31:0] data);
            marker_result_t got, want;
            got = data;
            results_seen++;
            if (owed_results.size() == 0)
                report_mismatch($sformatf("result %08h with nothing outstanding", data));
            else
            begin
                want = owed_results.pop_front();
                if (got.newly_marked !== want.newly_marked)
                    report_mismatch($sformatf("newly_marked %0d, predicted %0d",
                                              got.newly_marked, want.newly_marked));
                if (got.total_dirty !== want.total_dirty)
                    report_mismatch($sformatf("total_dirty %0d, predicted %0d",
                                              got.total_dirty, want.total_dirty));
                if (got.dirty_bit !== want.dirty_bit)
                    report_mismatch($sformatf("dirty_bit %b, predicted %b",
                                              got.dirty_bit, want.dirty_bit));
                if (got.index_error !== want.index_error)
                    report_mismatch($sformatf("index_error %b, predicted %b",
                                              got.index_error, want.index_error));
                if (got.pad !== 1'b0)
                    report_mismatch("padding bit of result not zero");
            end
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [gdwm_pkg::IDX_W-1:0]      s_tdata = '0;    // [15:0] cell_index
    logic [gdwm_pkg::FUNC_W-1:0]     s_tuser = '0;    // [1:0] func
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [gdwm_pkg::OUT_DW-1:0]     m_tdata;         // [11:0] newly_marked,
                                                      // [28:12] total_dirty,
                                                      // [29] dirty_bit, [30] index_error
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [gdwm_pkg::APB_AW-1:0]     paddr = '0;
    logic [gdwm_pkg::APB_DW-1:0]     pwdata = '0;
    logic [gdwm_pkg::APB_DW-1:0]     prdata;
    logic                            pready;

    dirty_map_scoreboard   map_sb;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    commands_sent = 0;
    int                    register_writes = 0;
    int                    stall_cycles = 0;
    logic [15:0]           last_mark = '0;

    grid_dirty_window_marker_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result side: check accepted transactions, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            map_sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no transaction on either stream
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // one command transaction, with random idle cycles ahead of it
    task automatic send_command(input logic [1:0] func, input logic [15:0] cell_index);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= cell_index;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        map_sb.note_command(func, cell_index);
        commands_sent++;
    endtask

    // wait until every owed result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (map_sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write followed by a read back of the same register
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        map_sb.write_register(index, value);
        register_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== map_sb.register_value(index))
            map_sb.report_mismatch($sformatf("register %0d reads %08h, written %08h",
                                             index, prdata, map_sb.register_value(index)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // new geometry, written only with the block idle; upper data bits are junk
    task automatic configure(input logic [8:0] w, input logic [8:0] h, input logic [4:0] r);
        settle();
        write_register(gdwm_pkg::REG_GRID_WIDTH,  {$urandom} & 32'hFFFF_FE00 | {23'd0, w});
        write_register(gdwm_pkg::REG_GRID_HEIGHT, {$urandom} & 32'hFFFF_FE00 | {23'd0, h});
        write_register(gdwm_pkg::REG_RADIUS,      {$urandom} & 32'hFFFF_FFE0 | {27'd0, r});
        last_mark = '0;
    endtask

    // random grid size: mostly ordinary, sometimes empty, tiny or saturated
    function automatic logic [8:0] random_side();
        int unsigned pick;
        pick = $urandom_range(19);
        case (pick)
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'($urandom_range(511, 257));
            4, 5:    return 9'($urandom_range(8, 2));
            default: return 9'($urandom_range(256, 1));
        endcase
    endfunction

    task automatic random_configure();
        logic [8:0] w, h;
        logic [4:0] r;
        w = random_side();
        h = random_side();
        if ($urandom_range(9) == 0)
        begin
            // wide windows only on narrow grids to keep marks short
            r = 5'($urandom_range(31, 7));
            if (w > 16)
                w = 9'($urandom_range(16, 1));
        end
        else
            r = 5'($urandom_range(6, 0));
        configure(w, h, r);
    endtask

    // random commands: marks and reads, many of the reads around the latest mark
    task automatic run_random(input int count);
        int unsigned n, w, r, pick;
        int          target, dy, dx;
        logic [1:0]  func;
        logic [15:0] cell_index;
        for (int i = 0; i < count; i++)
        begin
            n = map_sb.cells_in_use();
            w = map_sb.used_width();
            r = map_sb.used_radius();
            pick = $urandom_range(99);
            cell_index = 16'($urandom);
            if (pick < 4)
                func = gdwm_pkg::FUNC_CLEAR;
            else if (pick < 8)
                func = FUNC_NOP;
            else if (pick < 16)
            begin
                // outside the grid, unless the grid fills the whole map
                func = ($urandom_range(1)) ? gdwm_pkg::FUNC_MARK : gdwm_pkg::FUNC_READ;
                if (n < MAP_CELLS)
                    cell_index = 16'($urandom_range(65535, n));
            end
            else if (pick < 56)
            begin
                func = gdwm_pkg::FUNC_MARK;
                if (n != 0)
                    cell_index = 16'($urandom_range(n - 1, 0));
                last_mark = cell_index;
            end
            else if (pick < 78)
            begin
                // read near the latest mark, around the window edge too
                func = gdwm_pkg::FUNC_READ;
                if (n != 0)
                begin
                    dy = int'($urandom_range(2 * r + 2, 0)) - int'(r) - 1;
                    dx = int'($urandom_range(2 * r + 2, 0)) - int'(r) - 1;
                    target = int'(last_mark) + dy * int'(w) + dx;
                    if (target < 0)
                        target = 0;
                    if (target >= int'(n))
                        target = int'(n) - 1;
                    cell_index = 16'(target);
                end
            end
            else
            begin
                func = gdwm_pkg::FUNC_READ;
                if (n != 0)
                    cell_index = 16'($urandom_range(n - 1, 0));
            end
            send_command(func, cell_index);
        end
    endtask

    initial
    begin : stimulus
        int send_pct [3];
        int recv_pct [3];
        map_sb = new();
        send_pct = '{36, 56, 0};
        recv_pct = '{56, 36, 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default geometry: corners, overlap, unused code, clear
        send_command(gdwm_pkg::FUNC_READ,  16'd0);
        send_command(gdwm_pkg::FUNC_MARK,  16'd0);
        send_command(gdwm_pkg::FUNC_MARK,  16'hFFFF);
        send_command(gdwm_pkg::FUNC_READ,  16'hFFFF);
        send_command(gdwm_pkg::FUNC_READ,  16'd1027);
        send_command(gdwm_pkg::FUNC_READ,  16'd1029);
        send_command(gdwm_pkg::FUNC_MARK,  16'd2);
        send_command(FUNC_NOP,             16'hFFFF);
        send_command(gdwm_pkg::FUNC_CLEAR, 16'hFFFF);
        send_command(gdwm_pkg::FUNC_READ,  16'd0);
        send_command(gdwm_pkg::FUNC_MARK,  16'hAAAA);
        send_command(gdwm_pkg::FUNC_MARK,  16'h5555);

        // zero width: no cells at all
        configure(9'd0, 9'd256, 5'd4);
        send_command(gdwm_pkg::FUNC_MARK, 16'd0);
        send_command(gdwm_pkg::FUNC_READ, 16'd0);

        // saturated width, single row, widest window
        configure(9'd511, 9'd1, 5'd31);
        send_command(gdwm_pkg::FUNC_MARK, 16'd128);
        send_command(gdwm_pkg::FUNC_READ, 16'd255);
        send_command(gdwm_pkg::FUNC_READ, 16'd256);

        // single column, zero radius
        configure(9'd1, 9'd256, 5'd0);
        send_command(gdwm_pkg::FUNC_MARK, 16'd255);
        send_command(gdwm_pkg::FUNC_READ, 16'd255);
        send_command(gdwm_pkg::FUNC_READ, 16'd254);
        send_command(gdwm_pkg::FUNC_MARK, 16'd256);

        // odd grid: last cell and first index past it
        configure(9'd100, 9'd50, 5'd3);
        send_command(gdwm_pkg::FUNC_MARK, 16'd4999);
        send_command(gdwm_pkg::FUNC_MARK, 16'd5000);
        send_command(gdwm_pkg::FUNC_READ, 16'd4899);

        // zero height with saturated width
        configure(9'd300, 9'd0, 5'd2);
        send_command(gdwm_pkg::FUNC_MARK, 16'd3);

        // random part in three idling regimes
        for (int p = 0; p < 3; p++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                random_configure();
                send_idle_pct = send_pct[p];
                recv_idle_pct = recv_pct[p];
                run_random(100);
            end
        end

        // fill the whole map so the total reaches its top
        configure(9'd256, 9'd256, 5'd31);
        send_command(gdwm_pkg::FUNC_CLEAR, 16'd0);
        for (int y = 0; y < 5; y++)
            for (int x = 0; x < 5; x++)
                send_command(gdwm_pkg::FUNC_MARK, 16'(y * 63 * 256 + x * 63));
        send_command(gdwm_pkg::FUNC_READ, 16'd0);
        send_command(gdwm_pkg::FUNC_READ, 16'hFFFF);
        send_command(FUNC_NOP,            16'd0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (map_sb.pending() != 0)
            map_sb.report_mismatch($sformatf("%0d results never came", map_sb.pending()));
        $display("run covered %0d commands and %0d results over %0d register writes",
                 commands_sent, map_sb.results_seen, register_writes);
        $display("mismatches found: %0d", map_sb.mismatches);
        if (map_sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
